### rtl/pr2_pkg.sv
// ----------------------------------------------------------------------------
// pr2_pkg: shared constants and types for the 2x2 pixel reducer
// Holds the sizes, the register map and the item types that pass from the
// front part, through the window queue, to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package pr2_pkg;

    // Sizes
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 12;
    localparam int PIX_W      = 8;
    localparam int PAIR_DEPTH = MAX_WIDTH / 2;
    localparam int PAIR_AW    = COL_W - 1;
    localparam int MODE_W     = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Width limits
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(2048);

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_AVG      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RANK_MAX = 3'd4;

    // Register indexes (paddr bit 2)
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // Operation picked by the front part
    typedef struct packed {
        logic       avg;
        logic [1:0] rank;
    } op_t;

    // One complete 2x2 window
    typedef struct packed {
        pix_t a;
        pix_t b;
        pix_t c;
        pix_t d;
        logic row_end;
        op_t  op;
    } win_t;

endpackage

`default_nettype wire

### rtl/pr2_front.sv
// ----------------------------------------------------------------------------
// pr2_front: pixel intake, line store and window assembly
// Tracks column and row parity, keeps even rows in a pair-wide line store
// and emits one window item on each odd-row, odd-column pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2_front (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            accept,
    input  wire pr2_pkg::pix_t             pixel,
    input  wire                            frame_start,
    input  wire [pr2_pkg::MODE_W-1:0]      mode,
    input  wire [pr2_pkg::WIDTH_W-1:0]     line_width,
    output logic                           push,
    output pr2_pkg::win_t                  win
);

    // Line store: one word per column pair, left pixel in the low byte
    logic [2*pr2_pkg::PIX_W-1:0] pair_mem [pr2_pkg::PAIR_DEPTH];
    logic [2*pr2_pkg::PIX_W-1:0] rd_reg;

    logic [pr2_pkg::COL_W-1:0]   col_reg, col_next;
    logic                        odd_reg, odd_next;
    pr2_pkg::pix_t               held_reg;

    logic [pr2_pkg::WIDTH_W-1:0] eff_w;
    logic [pr2_pkg::COL_W-1:0]   col_in, col;
    logic                        row_in, row, wrap, last;
    logic [pr2_pkg::PAIR_AW-1:0] pair_addr;

    // Clamp the configured width
    always_comb
    begin
        if (line_width < pr2_pkg::WIDTH_MIN)
            eff_w = pr2_pkg::WIDTH_MIN;
        else if (line_width > pr2_pkg::WIDTH_MAX)
            eff_w = pr2_pkg::WIDTH_MAX;
        else
            eff_w = line_width;
    end

    // Position of this pixel: frame restart, then end a row that overran
    always_comb
    begin
        col_in    = frame_start ? '0 : col_reg;
        row_in    = frame_start ? 1'b0 : odd_reg;
        wrap      = pr2_pkg::WIDTH_W'(col_in) >= eff_w;
        col       = wrap ? '0 : col_in;
        row       = wrap ? ~row_in : row_in;
        last      = (pr2_pkg::WIDTH_W'(col) + pr2_pkg::WIDTH_W'(1)) >= eff_w;
        col_next  = last ? '0 : col + pr2_pkg::COL_W'(1);
        odd_next  = last ? ~row : row;
        pair_addr = col[pr2_pkg::COL_W-1:1];
    end

    // Build the window item
    always_comb
    begin
        push        = accept && row && col[0];
        win.a       = rd_reg[pr2_pkg::PIX_W-1:0];
        win.b       = rd_reg[2*pr2_pkg::PIX_W-1:pr2_pkg::PIX_W];
        win.c       = held_reg;
        win.d       = pixel;
        win.row_end = pr2_pkg::WIDTH_W'(col) ==
                      ((eff_w & ~pr2_pkg::WIDTH_W'(1)) - pr2_pkg::WIDTH_W'(1));
        win.op.avg  = (mode == pr2_pkg::MODE_AVG);
        if (mode > pr2_pkg::MODE_RANK_MAX)
            win.op.rank = 2'd3;
        else
            win.op.rank = 2'(mode - 3'd1);
    end

    // Advance counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            odd_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            odd_reg <= odd_next;
        end
    end

    // Hold the left pixel of each pair, write and read the line store
    always_ff @(posedge clk)
    begin
        if (accept && !col[0])
        begin
            held_reg <= pixel;
            if (row)
                rd_reg <= pair_mem[pair_addr];
        end
        // Store each even-row pixel in its own byte of the pair word
        if (accept && !row)
        begin
            if (col[0])
                pair_mem[pair_addr][2*pr2_pkg::PIX_W-1:pr2_pkg::PIX_W] <= pixel;
            else
                pair_mem[pair_addr][pr2_pkg::PIX_W-1:0] <= pixel;
        end
    end

endmodule

`default_nettype wire

### rtl/pr2_queue.sv
// ----------------------------------------------------------------------------
// pr2_queue: short window queue between front and back
// Four-entry first-in first-out store of window items.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire pr2_pkg::win_t  push_win,
    input  wire                 pop,
    output pr2_pkg::win_t       head,
    output logic                full,
    output logic                empty
);

    pr2_pkg::win_t                slot_mem [pr2_pkg::FIFO_DEPTH];
    logic [pr2_pkg::FIFO_AW-1:0]  wr_reg, rd_reg;
    logic [pr2_pkg::FIFO_AW:0]    cnt_reg, cnt_next;

    assign head  = slot_mem[rd_reg];
    assign full  = (cnt_reg == (pr2_pkg::FIFO_AW+1)'(pr2_pkg::FIFO_DEPTH));
    assign empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // Store item
    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_reg] <= push_win;
    end

endmodule

`default_nettype wire

### rtl/pr2_back.sv
// ----------------------------------------------------------------------------
// pr2_back: window reduction and output register
// Averages or ranks the four pixels of the queue head and holds the result
// in the output register until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire pr2_pkg::win_t  head,
    input  wire                 empty,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output pr2_pkg::pix_t       out_pixel,
    output logic                out_last
);

    logic          valid_reg;
    pr2_pkg::pix_t pix_reg, pix_next;
    logic          last_reg;
    logic [pr2_pkg::PIX_W+1:0] sum;
    pr2_pkg::pix_t v0, v1, v2, v3, w0, w1, w2, w3, x1, x2;
    pr2_pkg::pix_t ranked;

    // Sort the four pixels
    always_comb
    begin
        v0 = (head.b < head.a) ? head.b : head.a;
        v1 = (head.b < head.a) ? head.a : head.b;
        v2 = (head.d < head.c) ? head.d : head.c;
        v3 = (head.d < head.c) ? head.c : head.d;
        w0 = (v2 < v0) ? v2 : v0;
        w2 = (v2 < v0) ? v0 : v2;
        w1 = (v3 < v1) ? v3 : v1;
        w3 = (v3 < v1) ? v1 : v3;
        x1 = (w2 < w1) ? w2 : w1;
        x2 = (w2 < w1) ? w1 : w2;
        unique case (head.op.rank)
            2'd0:    ranked = w0;
            2'd1:    ranked = x1;
            2'd2:    ranked = x2;
            default: ranked = w3;
        endcase
    end

    // Truncated average or picked rank
    always_comb
    begin
        sum = {2'b00, head.a} + {2'b00, head.b} + {2'b00, head.c} + {2'b00, head.d};
        pix_next = head.op.avg ? sum[pr2_pkg::PIX_W+1:2] : ranked;
    end

    assign pop       = !empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_pixel = pix_reg;
    assign out_last  = last_reg;

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || out_ready)
            valid_reg <= !empty;
    end

    // Load result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pix_reg  <= pix_next;
            last_reg <= head.row_end;
        end
    end

endmodule

`default_nettype wire

### rtl/pixel_reduce_2x2_average_or_rank.sv
// A pixel that completes a 2x2 window pushes it into the window queue; the back
// part then loads it into the output register, from which the sink takes it.
// Throughput: one pixel per cycle, at most one output per two pixels; the
// four-entry window queue lets input go on while output stalls, until it is full.
// Reset: rst_n clears counters, queue and output valid; mode 0, width 2048.
// The line store is not cleared; even rows fill it before odd rows read it.
// ----------------------------------------------------------------------------
// pixel_reduce_2x2_average_or_rank: 2x2 reducer top level
// Configuration registers, front part, window queue and back part.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_reduce_2x2_average_or_rank (
    input  wire                           clk,
    input  wire                           rst_n,
    // Pixel input
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [7:0]                    s_tdata,   // [7:0] pixel
    input  wire                           s_tuser,   // [0] frame_start
    // Reduced output
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_pixel
    output logic                          m_tlast,   // row_end
    // Configuration
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [pr2_pkg::ADDR_W-1:0]    paddr,
    input  wire  [pr2_pkg::DATA_W-1:0]    pwdata,
    output logic [pr2_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [pr2_pkg::MODE_W-1:0]  mode_reg;
    logic [pr2_pkg::WIDTH_W-1:0] width_reg;
    logic                        cfg_wr, accept, push, pop, full, empty;
    pr2_pkg::win_t               push_win, head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pr2_pkg::MODE_AVG;
            width_reg <= pr2_pkg::WIDTH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                pr2_pkg::REG_MODE:  mode_reg  <= pwdata[pr2_pkg::MODE_W-1:0];
                pr2_pkg::REG_WIDTH: width_reg <= pwdata[pr2_pkg::WIDTH_W-1:0];
                default:            mode_reg  <= mode_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[2])
            pr2_pkg::REG_MODE:  prdata = pr2_pkg::DATA_W'(mode_reg);
            pr2_pkg::REG_WIDTH: prdata = pr2_pkg::DATA_W'(width_reg);
            default:            prdata = '0;
        endcase
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    pr2_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (s_tdata),
        .frame_start (s_tuser),
        .mode        (mode_reg),
        .line_width  (width_reg),
        .push        (push),
        .win         (push_win)
    );

    pr2_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_win (push_win),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    pr2_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/pr2_checker.sv
// ----------------------------------------------------------------------------
// pr2_checker: port-level checks for the 2x2 reducer
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [7:0]                    m_tdata,
    input wire                          m_tlast,
    input wire                          psel,
    input wire                          penable,
    input wire                          pwrite,
    input wire [pr2_pkg::ADDR_W-1:0]    paddr,
    input wire [pr2_pkg::DATA_W-1:0]    pwdata,
    input wire [pr2_pkg::DATA_W-1:0]    prdata,
    input wire                          pready
);

    // Stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Mode write is read back on the next cycle
    a_mode_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == pr2_pkg::REG_MODE)
        ##1 (paddr[2] == pr2_pkg::REG_MODE)
        |-> prdata == pr2_pkg::DATA_W'($past(pwdata[pr2_pkg::MODE_W-1:0])))
        else $error("mode readback mismatch");

    // Width write is read back on the next cycle
    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == pr2_pkg::REG_WIDTH)
        ##1 (paddr[2] == pr2_pkg::REG_WIDTH)
        |-> prdata == pr2_pkg::DATA_W'($past(pwdata[pr2_pkg::WIDTH_W-1:0])))
        else $error("line width readback mismatch");

    // Output valid rises only after an accepted input item passes the queue
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output item without input");

endmodule

bind pixel_reduce_2x2_average_or_rank pr2_checker u_pr2_checker (.*);

`default_nettype wire

### sim/pixel_reduce_2x2_average_or_rank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_reduce_2x2_average_or_rank_tb: self-checking bench for the 2x2 reducer
// Streams raster pixel frames into the block under random gaps and output
// stalls. A local model of the line store and window logic predicts every
// reduced pixel and its row_end flag, and each output item is checked in order.
// ----------------------------------------------------------------------------

module pixel_reduce_2x2_average_or_rank_tb;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 16;

    typedef struct {
        pr2_pkg::pix_t out_pixel;
        logic          row_end;
    } reduced_t;

    // Block ports; the driven inputs are known from time zero
    logic                        clk     = 1'b0;
    logic                        rst_n   = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata = 8'd0;   // [7:0] pixel
    logic                        s_tuser = 1'b0;   // [0] frame_start
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [7:0]                  m_tdata;          // [7:0] out_pixel
    logic                        m_tlast;          // row_end
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [pr2_pkg::ADDR_W-1:0]  paddr   = '0;
    logic [pr2_pkg::DATA_W-1:0]  pwdata  = '0;
    logic [pr2_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // Predicted block state and configuration
    pr2_pkg::pix_t               line_copy [pr2_pkg::MAX_WIDTH];
    bit                          line_copy_written [pr2_pkg::MAX_WIDTH];
    int unsigned                 pred_col;
    bit                          pred_odd_row;
    pr2_pkg::pix_t               pred_held_left;
    logic [pr2_pkg::MODE_W-1:0]  cfg_mode;
    logic [pr2_pkg::WIDTH_W-1:0] cfg_width;

    // Expected reduced pixels, oldest first
    reduced_t           pending_reduced [$];

    int                 error_count  = 0;
    int                 items_sent   = 0;
    int                 cycle_count  = 0;
    bit                 idle_on      = 1'b1;
    int                 hold_request = 0;

    pixel_reduce_2x2_average_or_rank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pixel_reduce_2x2_average_or_rank_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic int unsigned active_width();
        int unsigned w;
        w = cfg_width;
        if (w < pr2_pkg::WIDTH_MIN) w = pr2_pkg::WIDTH_MIN;
        if (w > pr2_pkg::WIDTH_MAX) w = pr2_pkg::WIDTH_MAX;
        return w;
    endfunction

    function automatic pr2_pkg::pix_t reduce_window(pr2_pkg::pix_t a, pr2_pkg::pix_t b,
                                                    pr2_pkg::pix_t c, pr2_pkg::pix_t d);
        int unsigned v [4];
        int unsigned t;
        int unsigned k;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        if (cfg_mode == pr2_pkg::MODE_AVG)
            return pr2_pkg::pix_t'((v[0] + v[1] + v[2] + v[3]) >> 2);
        // Sort ascending, then pick rank k; unused modes pick the largest
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (v[j + 1] < v[j])
                begin
                    t        = v[j];
                    v[j]     = v[j + 1];
                    v[j + 1] = t;
                end
        k = (cfg_mode > pr2_pkg::MODE_RANK_MAX) ? pr2_pkg::MODE_RANK_MAX : cfg_mode;
        return pr2_pkg::pix_t'(v[k - 1]);
    endfunction

    // True when this pixel would close a window over a never-written entry
    function automatic bit hits_unwritten(logic frame_start);
        int unsigned w;
        int unsigned col;
        bit          odd;
        w   = active_width();
        col = frame_start ? 0 : pred_col;
        odd = frame_start ? 1'b0 : pred_odd_row;
        if (col >= w)
        begin
            col = 0;
            odd = ~odd;
        end
        if (!odd || (col % 2 == 0))
            return 1'b0;
        return !(line_copy_written[col - 1] && line_copy_written[col]);
    endfunction

    task automatic predict_pixel(pr2_pkg::pix_t pix, logic frame_start);
        int unsigned w;
        int unsigned col;
        reduced_t    r;
        w = active_width();
        if (frame_start)
        begin
            pred_col     = 0;
            pred_odd_row = 1'b0;
        end
        // End a row that outgrew a lowered width
        if (pred_col >= w)
        begin
            pred_col     = 0;
            pred_odd_row = ~pred_odd_row;
        end
        col = pred_col;
        if (!pred_odd_row)
        begin
            line_copy[col]         = pix;
            line_copy_written[col] = 1'b1;
        end
        else if (col % 2 == 0)
            pred_held_left = pix;
        else
        begin
            r.out_pixel = reduce_window(line_copy[col - 1], line_copy[col],
                                        pred_held_left, pix);
            r.row_end   = (col == (w & ~32'd1) - 1);
            pending_reduced.push_back(r);
        end
        if (col + 1 >= w)
        begin
            pred_col     = 0;
            pred_odd_row = ~pred_odd_row;
        end
        else
            pred_col = col + 1;
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d, want %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    initial
    begin : output_check
        reduced_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_reduced.size() == 0)
                    report_mismatch("unexpected item, out_pixel", m_tdata, -1);
                else
                begin
                    want = pending_reduced.pop_front();
                    if (m_tdata !== want.out_pixel)
                        report_mismatch("out_pixel", m_tdata, want.out_pixel);
                    if (m_tlast !== want.row_end)
                        report_mismatch("row_end", m_tlast, want.row_end);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stall bursts and long requested hold-offs
    // ------------------------------------------------------------------------

    initial
    begin : output_stall
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (burst_left > 0)
            begin
                m_tready <= 1'b0;
                burst_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready   <= 1'b0;
                burst_left = $urandom_range(1, 5) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    task automatic send_pixel(pr2_pkg::pix_t pix, logic frame_start);
        int gap;
        // Restart the frame rather than read a store entry never written
        if (hits_unwritten(frame_start))
            frame_start = 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= frame_start;
        do
            @(posedge clk);
        while (!s_tready);
        predict_pixel(pix, frame_start);
        items_sent++;
    endtask

    function automatic pr2_pkg::pix_t random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return pr2_pkg::pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Send rows of random pixels; noisy rows may restart or end early
    task automatic send_rows(int rows, int cols, bit with_start, bit noisy);
        logic fs;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                fs = with_start && r == 0 && c == 0;
                if (noisy && $urandom_range(0, 59) == 0)
                    fs = 1'b1;
                send_pixel(random_pixel(), fs);
                if (noisy && $urandom_range(0, 79) == 0)
                    break;
            end
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_reduced.size() != 0)
            @(posedge clk);
    endtask

    // Let the block go idle before a register write
    task automatic settle_block();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic reg_index, logic [pr2_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == pr2_pkg::REG_MODE)
            cfg_mode = value[pr2_pkg::MODE_W-1:0];
        else
            cfg_width = value[pr2_pkg::WIDTH_W-1:0];
    endtask

    task automatic configure(logic [pr2_pkg::DATA_W-1:0] mode,
                             logic [pr2_pkg::DATA_W-1:0] width);
        settle_block();
        write_register(pr2_pkg::REG_MODE, mode);
        write_register(pr2_pkg::REG_WIDTH, width);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Full-scale and near-zero windows in average mode
    task automatic test_extremes();
        configure(pr2_pkg::MODE_AVG, 2);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b0);
        send_pixel(8'd3, 1'b0);
    endtask

    // Every rank, plus the unused modes that act as largest
    task automatic test_rank_modes();
        for (int m = 1; m < 8; m++)
        begin
            configure(m, 2);
            send_pixel(8'd40, 1'b1);
            send_pixel(8'd10, 1'b0);
            send_pixel(8'd30, 1'b0);
            send_pixel(8'd20, 1'b0);
        end
    endtask

    // Odd last column is dropped; a trailing even row gives nothing
    task automatic test_odd_width();
        configure(2, 3);
        send_rows(3, 3, 1'b1, 1'b0);
    endtask

    // Widths below the minimum clamp to two
    task automatic test_width_clamp_low();
        configure(3, 0);
        send_rows(2, 2, 1'b1, 1'b0);
        configure(1, 1);
        send_rows(2, 2, 1'b1, 1'b0);
    endtask

    // Lower the width in the middle of an even row, then of an odd row
    task automatic test_width_lowered();
        configure(pr2_pkg::MODE_AVG, 8);
        send_rows(1, 6, 1'b1, 1'b0);
        configure(pr2_pkg::MODE_AVG, 4);
        send_rows(3, 4, 1'b0, 1'b0);
        configure(4, 8);
        send_rows(1, 8, 1'b1, 1'b0);
        send_rows(1, 6, 1'b0, 1'b0);
        configure(4, 4);
        send_rows(2, 4, 1'b0, 1'b0);
    endtask

    // Widths above the maximum clamp to the full line store: a short row never wraps
    task automatic test_widest_line();
        configure(pr2_pkg::MODE_RANK_MAX, 12'hFFF);
        send_rows(1, 24, 1'b1, 1'b0);
    endtask

    task automatic random_phase(int budget);
        int target;
        int pick;
        logic [pr2_pkg::DATA_W-1:0] width;
        target = items_sent + budget;
        pick   = $urandom_range(0, 19);
        if (pick == 0)
            width = $urandom_range(0, 1);
        else if (pick == 1)
            width = $urandom_range(17, 64);
        else
            width = $urandom_range(2, 16);
        configure($urandom_range(0, 7), width);
        while (items_sent < target)
            send_rows($urandom_range(1, 6), active_width(),
                      $urandom_range(0, 4) != 0, 1'b1);
    endtask

    task automatic test_random_frames();
        for (int p = 0; p < 18; p++)
            random_phase(40);
    endtask

    // Hold the output off long enough for the block to stall its input
    task automatic test_output_stall();
        configure($urandom_range(0, 4), 6);
        @(negedge clk);
        hold_request = 300;
        send_rows(14, 6, 1'b1, 1'b0);
    endtask

    // Pause the input until every result is out, then carry on mid-frame
    task automatic test_sender_pause();
        configure($urandom_range(0, 7), 10);
        send_rows(3, 10, 1'b1, 1'b0);
        send_pixel(random_pixel(), 1'b0);
        wait_for_results();
        send_rows(3, 10, 1'b0, 1'b0);
    endtask

    // Back-to-back traffic on both sides
    task automatic test_full_rate();
        idle_on = 1'b0;
        for (int p = 0; p < 4; p++)
            random_phase(40);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        pred_col       = 0;
        pred_odd_row   = 1'b0;
        pred_held_left = '0;
        cfg_mode       = pr2_pkg::MODE_AVG;
        cfg_width      = pr2_pkg::WIDTH_RESET;
        foreach (line_copy_written[i])
            line_copy_written[i] = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_rank_modes();
        test_odd_width();
        test_width_clamp_low();
        test_width_lowered();
        test_widest_line();
        test_random_frames();
        test_output_stall();
        test_sender_pause();
        test_full_rate();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_reduced.size() == 0)
            $display("pixel_reduce_2x2_average_or_rank_tb: clean");
        else
            $display("pixel_reduce_2x2_average_or_rank_tb: errors");
        $finish;
    end

endmodule

### pixel_reduce_2x2_average_or_rank.f
rtl/pr2_pkg.sv
rtl/pr2_front.sv
rtl/pr2_queue.sv
rtl/pr2_back.sv
rtl/pixel_reduce_2x2_average_or_rank.sv
rtl/pr2_checker.sv
sim/pixel_reduce_2x2_average_or_rank_tb.sv
